// ===== rtl/kct_pkg.sv =====
// shared types, constants and helpers for the kinematic collision time block
package kct_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_NOREL  = 2'd1;
    localparam t_status ST_NOROOT = 2'd2;
    localparam t_status ST_SAT    = 2'd3;

    // pipeline depth of one axis: 3 front stages, square root, numerator, divider, output
    function automatic int kct_latency(input int w, input int f);
        return 2 * w + f + 9;
    endfunction

endpackage

// ===== rtl/kct_if.sv =====
// item channels: body operands in, per-axis meeting times out
interface kct_in_if #(parameter int WORD_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] pos_a_x;
    logic signed [WORD_BITS-1:0] vel_a_x;
    logic signed [WORD_BITS-1:0] acc_a_x;
    logic signed [WORD_BITS-1:0] pos_b_x;
    logic signed [WORD_BITS-1:0] vel_b_x;
    logic signed [WORD_BITS-1:0] acc_b_x;
    logic signed [WORD_BITS-1:0] pos_a_y;
    logic signed [WORD_BITS-1:0] vel_a_y;
    logic signed [WORD_BITS-1:0] acc_a_y;
    logic signed [WORD_BITS-1:0] pos_b_y;
    logic signed [WORD_BITS-1:0] vel_b_y;
    logic signed [WORD_BITS-1:0] acc_b_y;

    modport source (
        output valid, pos_a_x, vel_a_x, acc_a_x, pos_b_x, vel_b_x, acc_b_x,
               pos_a_y, vel_a_y, acc_a_y, pos_b_y, vel_b_y, acc_b_y,
        input  ready
    );
    modport sink (
        input  valid, pos_a_x, vel_a_x, acc_a_x, pos_b_x, vel_b_x, acc_b_x,
               pos_a_y, vel_a_y, acc_a_y, pos_b_y, vel_b_y, acc_b_y,
        output ready
    );
endinterface

interface kct_out_if #(parameter int WORD_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] time_x;
    logic [1:0]                  status_x;
    logic signed [WORD_BITS-1:0] time_y;
    logic [1:0]                  status_y;

    modport source (output valid, time_x, status_x, time_y, status_y, input ready);
    modport sink   (input valid, time_x, status_x, time_y, status_y, output ready);
endinterface

// ===== rtl/kct_axis.sv =====
// one axis datapath: differences, discriminant, pipelined square root and divider
module kct_axis
    import kct_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_pa,
    input  logic signed [WORD_BITS-1:0] i_va,
    input  logic signed [WORD_BITS-1:0] i_aa,
    input  logic signed [WORD_BITS-1:0] i_pb,
    input  logic signed [WORD_BITS-1:0] i_vb,
    input  logic signed [WORD_BITS-1:0] i_ab,
    output logic signed [WORD_BITS-1:0] o_time,
    output t_status                     o_status
);

    localparam int W     = WORD_BITS;
    localparam int DW    = W + 1;          // difference width
    localparam int DISCW = 2 * DW + 2;     // discriminant width
    localparam int RW    = DISCW / 2;      // root width
    localparam int REMW  = RW + 3;         // root remainder width
    localparam int NW    = W + 3;          // signed numerator width
    localparam int NMW   = W + 2;          // numerator magnitude width
    localparam int QN    = NMW + FRAC_BITS;// quotient bits, one per stage
    localparam int DMW   = DW;             // divisor magnitude width

    typedef struct packed {
        logic [DISCW-1:0]    n;
        logic [REMW-1:0]     rem;
        logic [RW-1:0]       root;
        logic signed [DW-1:0] dv;
        logic signed [DW-1:0] da;
        logic signed [DW-1:0] dp;
        logic                lin;
        logic                norel;
        logic                noroot;
    } t_sq;

    typedef struct packed {
        logic [QN-1:0]  num;
        logic [DMW-1:0] den;
        logic [DMW:0]   rem;
        logic [QN-1:0]  q;
        logic           neg;
        logic           spec;
        t_status        st;
    } t_dq;

    // front stage: differences
    logic signed [DW-1:0] r0_dv, r0_da, r0_dp;
    logic                 r0_lin;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_dv  <= {i_va[W-1], i_va} - {i_vb[W-1], i_vb};
            r0_da  <= {i_aa[W-1], i_aa} - {i_ab[W-1], i_ab};
            r0_dp  <= {i_pa[W-1], i_pa} - {i_pb[W-1], i_pb};
            r0_lin <= (i_aa == i_ab);
        end
    end

    // product stage: squared velocity difference and acceleration times position
    logic [DW-1:0]        m_dv, m_da, m_dp;
    logic [2*DW-1:0]      r1_sq, r1_pr;
    logic signed [DW-1:0] r1_dv, r1_da, r1_dp;
    logic                 r1_lin, r1_opp;

    assign m_dv = r0_dv[DW-1] ? DW'(-r0_dv) : DW'(r0_dv);
    assign m_da = r0_da[DW-1] ? DW'(-r0_da) : DW'(r0_da);
    assign m_dp = r0_dp[DW-1] ? DW'(-r0_dp) : DW'(r0_dp);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq  <= m_dv * m_dv;
            r1_pr  <= m_da * m_dp;
            r1_opp <= r0_da[DW-1] ^ r0_dp[DW-1];
            r1_dv  <= r0_dv;
            r1_da  <= r0_da;
            r1_dp  <= r0_dp;
            r1_lin <= r0_lin;
        end
    end

    // discriminant stage
    t_sq              r_sq [0:RW];
    logic [DISCW-1:0] sq_x, term_x;

    assign sq_x   = DISCW'(r1_sq);
    assign term_x = DISCW'({r1_pr, 1'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0].n      <= r1_opp ? sq_x + term_x : sq_x - term_x;
            r_sq[0].rem    <= '0;
            r_sq[0].root   <= '0;
            r_sq[0].dv     <= r1_dv;
            r_sq[0].da     <= r1_da;
            r_sq[0].dp     <= r1_dp;
            r_sq[0].lin    <= r1_lin;
            r_sq[0].norel  <= r1_lin && (r1_dv == '0);
            r_sq[0].noroot <= !r1_lin && !r1_opp && (term_x > sq_x);
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [REMW-1:0] rs, trial;
        logic            ge;
        t_sq             n_sq;

        assign rs    = {r_sq[k].rem[REMW-3:0], r_sq[k].n[DISCW-1:DISCW-2]};
        assign trial = REMW'({r_sq[k].root, 2'b01});
        assign ge    = (rs >= trial);

        always_comb begin
            n_sq      = r_sq[k];
            n_sq.n    = {r_sq[k].n[DISCW-3:0], 2'b00};
            n_sq.rem  = ge ? rs - trial : rs;
            n_sq.root = {r_sq[k].root[RW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k+1] <= n_sq;
            end
        end
    end

    // numerator stage: pick linear or quadratic form, split into sign and magnitude
    t_dq                  r_dq [0:QN];
    t_sq                  sq_e;
    logic signed [NW-1:0] dp_x, dv_x, s_x, num;
    logic signed [DW-1:0] den;
    logic [NW-1:0]        num_mag;
    logic [DMW-1:0]       den_mag;

    assign sq_e    = r_sq[RW];
    assign dp_x    = {{(NW-DW){sq_e.dp[DW-1]}}, sq_e.dp};
    assign dv_x    = {{(NW-DW){sq_e.dv[DW-1]}}, sq_e.dv};
    assign s_x     = {{(NW-RW){1'b0}}, sq_e.root};
    assign num     = sq_e.lin ? -dp_x : -dv_x - s_x;
    assign den     = sq_e.lin ? sq_e.dv : sq_e.da;
    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_mag = den[DW-1] ? DMW'(-den) : DMW'(den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dq[0].num  <= {num_mag[NMW-1:0], {FRAC_BITS{1'b0}}};
            r_dq[0].den  <= den_mag;
            r_dq[0].rem  <= '0;
            r_dq[0].q    <= '0;
            r_dq[0].neg  <= num[NW-1] ^ den[DW-1];
            r_dq[0].spec <= sq_e.norel || sq_e.noroot;
            r_dq[0].st   <= sq_e.norel ? ST_NOREL : ST_NOROOT;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QN; k++) begin : g_div
        logic [DMW:0] rs;
        logic         ge;
        t_dq          n_dq;

        assign rs = {r_dq[k].rem[DMW-1:0], r_dq[k].num[QN-1]};
        assign ge = (rs >= {1'b0, r_dq[k].den});

        always_comb begin
            n_dq     = r_dq[k];
            n_dq.num = {r_dq[k].num[QN-2:0], 1'b0};
            n_dq.rem = ge ? rs - {1'b0, r_dq[k].den} : rs;
            n_dq.q   = {r_dq[k].q[QN-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[k+1] <= n_dq;
            end
        end
    end

    // output stage: sign, saturation and special cases
    t_dq          dq_e;
    logic         neg, ovf;
    logic [W-1:0] q_lo;

    assign dq_e = r_dq[QN];
    assign neg  = dq_e.neg && (dq_e.q != '0);
    assign q_lo = dq_e.q[W-1:0];
    assign ovf  = neg ? ((|dq_e.q[QN-1:W]) || (dq_e.q[W-1] && (|dq_e.q[W-2:0])))
                      : (|dq_e.q[QN-1:W-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (dq_e.spec) begin
                o_time   <= '0;
                o_status <= dq_e.st;
            end else if (ovf) begin
                o_time   <= neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                o_status <= ST_SAT;
            end else begin
                o_time   <= neg ? -q_lo : q_lo;
                o_status <= ST_OK;
            end
        end
    end

endmodule

// ===== rtl/kinematic_collision_time_top.sv =====
// top level: two axis pipelines, valid chain and two-entry output buffer
//
// Takes one item per cycle while the output buffer is not full and returns
// the meeting time per axis once the item has passed through every axis
// stage; a result may then wait in the output buffer. The depth comes from
// the square root, one root bit per stage, and the restoring divider, one
// quotient bit per stage. The whole pipeline holds while the two-entry
// output buffer is full, so a stall on the output loses nothing and the
// input keeps being taken while one finished result still waits.
module kinematic_collision_time_top
    import kct_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kct_in_if.sink    i_in,
    kct_out_if.source o_out
);

    localparam int LAT = kct_latency(WORD_BITS, FRAC_BITS);

    logic                        en, push, pop;
    logic [LAT-1:0]              r_vld;
    logic [1:0]                  r_cnt;
    logic                        r_wp, r_rp;
    logic signed [WORD_BITS-1:0] tx, ty;
    t_status                     sx, sy;
    logic signed [WORD_BITS-1:0] r_tx [0:1];
    logic signed [WORD_BITS-1:0] r_ty [0:1];
    t_status                     r_sx [0:1];
    t_status                     r_sy [0:1];

    // pipeline moves whenever the buffer is not full
    assign en          = (r_cnt != 2'd2);
    assign i_in.ready  = en;
    assign push        = en && r_vld[LAT-1];
    assign pop         = o_out.valid && o_out.ready;

    kct_axis #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pa     (i_in.pos_a_x),
        .i_va     (i_in.vel_a_x),
        .i_aa     (i_in.acc_a_x),
        .i_pb     (i_in.pos_b_x),
        .i_vb     (i_in.vel_b_x),
        .i_ab     (i_in.acc_b_x),
        .o_time   (tx),
        .o_status (sx)
    );

    kct_axis #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pa     (i_in.pos_a_y),
        .i_va     (i_in.vel_a_y),
        .i_aa     (i_in.acc_a_y),
        .i_pb     (i_in.pos_b_y),
        .i_vb     (i_in.vel_b_y),
        .i_ab     (i_in.acc_b_y),
        .o_time   (ty),
        .o_status (sy)
    );

    // valid bits travel alongside the axis stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // output buffer pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // output buffer storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_tx[r_wp] <= tx;
            r_ty[r_wp] <= ty;
            r_sx[r_wp] <= sx;
            r_sy[r_wp] <= sy;
        end
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.time_x   = r_tx[r_rp];
    assign o_out.time_y   = r_ty[r_rp];
    assign o_out.status_x = r_sx[r_rp];
    assign o_out.status_y = r_sy[r_rp];

    // a full buffer must never take another result
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push)
        else $error("output buffer overfilled");

    // count stays within the buffer depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    // flagged x results carry a zero time
    a_spec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status_x == ST_NOREL || o_out.status_x == ST_NOROOT))
        |-> (o_out.time_x == '0))
        else $error("flagged x result with nonzero time");

    // saturated y results sit at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status_y == ST_SAT)
        |-> (o_out.time_y == {1'b1, {(WORD_BITS-1){1'b0}}} ||
             o_out.time_y == {1'b0, {(WORD_BITS-1){1'b1}}}))
        else $error("saturated y result not at a limit");

endmodule

// ===== dv/kct_tb_checker.sv =====
// checker for the collision time block: predicts per-axis meeting times and compares results
module kct_tb_checker
    import kct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    kct_in_if.sink    i_in_mon,
    kct_out_if.sink   i_out_mon,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] time_x;
        t_status            status_x;
        logic signed [31:0] time_y;
        t_status            status_y;
    } t_meet;

    t_meet meet_q[$];
    int    fail_count = 0;
    int    results_seen = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = meet_q.size();
    assign o_results_seen = results_seen;

    // one mismatch line per failure
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    // q16.16 quotient truncated toward zero, saturated to 32 bits
    function automatic logic signed [31:0] q_divide(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    output t_status st);
        logic [127:0] mn, md, q;
        logic         neg;
        mn  = num < 0 ? -num : num;
        md  = den < 0 ? -den : den;
        q   = (mn << 16) / md;
        neg = ((num < 0) != (den < 0)) && q != 0;
        if (neg && q > 128'h8000_0000) begin
            st = ST_SAT;
            return 32'sh8000_0000;
        end
        if (!neg && q > 128'h7fff_ffff) begin
            st = ST_SAT;
            return 32'sh7fff_ffff;
        end
        st = ST_OK;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // floor integer square root
    function automatic logic [127:0] int_sqrt(input logic [127:0] n);
        logic [127:0] res, bitv, t;
        res  = 0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            t = res + bitv;
            if (n >= t) begin
                n   = n - t;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // meeting time on one axis
    function automatic logic signed [31:0] axis_meet(
        input logic signed [31:0] pa, va, aa, pb, vb, ab, output t_status st);
        logic signed [127:0] dv, da, dp, disc, s;
        dv = 128'(va) - 128'(vb);
        if (aa == ab) begin
            if (dv == 0) begin
                st = ST_NOREL;
                return '0;
            end
            return q_divide(128'(pb) - 128'(pa), dv, st);
        end
        da   = 128'(aa) - 128'(ab);
        dp   = 128'(pa) - 128'(pb);
        disc = dv * dv - 2 * da * dp;
        if (disc < 0) begin
            st = ST_NOROOT;
            return '0;
        end
        s = $signed(int_sqrt(disc));
        return q_divide(-dv - s, da, st);
    endfunction

    // predict on every accepted input item, compare every accepted result
    always @(posedge i_clk) begin
        t_meet m, want;
        if (i_rst_n && i_in_mon.valid && i_in_mon.ready) begin
            m.time_x = axis_meet(i_in_mon.pos_a_x, i_in_mon.vel_a_x, i_in_mon.acc_a_x,
                                 i_in_mon.pos_b_x, i_in_mon.vel_b_x, i_in_mon.acc_b_x,
                                 m.status_x);
            m.time_y = axis_meet(i_in_mon.pos_a_y, i_in_mon.vel_a_y, i_in_mon.acc_a_y,
                                 i_in_mon.pos_b_y, i_in_mon.vel_b_y, i_in_mon.acc_b_y,
                                 m.status_y);
            meet_q.push_back(m);
        end
        if (i_rst_n && i_out_mon.valid && i_out_mon.ready) begin
            if (meet_q.size() == 0) begin
                fail_count++;
                $display("unexpected result with nothing pending");
            end else begin
                want = meet_q.pop_front();
                if (i_out_mon.time_x !== want.time_x)
                    report_mismatch("time_x", i_out_mon.time_x, want.time_x);
                if (i_out_mon.status_x !== want.status_x)
                    report_mismatch("status_x", 32'(i_out_mon.status_x), 32'(want.status_x));
                if (i_out_mon.time_y !== want.time_y)
                    report_mismatch("time_y", i_out_mon.time_y, want.time_y);
                if (i_out_mon.status_y !== want.status_y)
                    report_mismatch("status_y", 32'(i_out_mon.status_y), 32'(want.status_y));
            end
            results_seen++;
        end
    end
endmodule

// ===== dv/kinematic_collision_time_top_tb.sv =====
// testbench top: clock, reset, stimulus, output stalls and verdict
module kinematic_collision_time_top_tb
    import kct_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = kct_latency(32, 16);
    localparam int RAND_ITEMS = 1430;
    localparam int WATCHDOG  = 4000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, results_seen;
    int   idle_cycles;
    int   items_sent;
    int   out_wait;

    kct_in_if  #(.WORD_BITS(32)) in_ch();
    kct_out_if #(.WORD_BITS(32)) out_ch();

    kinematic_collision_time_top #(.WORD_BITS(32), .FRAC_BITS(16)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    kct_tb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // pick an edge value or a random word
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000) << 16;
            3: return $urandom_range(0, 255) - 128;
            default: return $urandom();
        endcase
    endfunction

    // random axis operands, often with equal accelerations or velocities
    task automatic rand_axis(output logic [31:0] p[6]);
        int shape;
        foreach (p[k]) p[k] = pick_word();
        shape = $urandom_range(0, 9);
        if (shape < 3) p[5] = p[2];
        if (shape == 3) begin
            p[5] = p[2];
            p[4] = p[1];
        end
        if (shape == 4) begin
            // small well-behaved values, usually a real root
            foreach (p[k]) p[k] = 32'(signed'($urandom_range(0, 512)) - 256) << 12;
        end
    endtask

    // drive one item and wait for its acceptance; with no gap valid stays up
    task automatic send_item(input logic [31:0] x[6], input logic [31:0] y[6]);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.pos_a_x <= x[0]; in_ch.vel_a_x <= x[1]; in_ch.acc_a_x <= x[2];
        in_ch.pos_b_x <= x[3]; in_ch.vel_b_x <= x[4]; in_ch.acc_b_x <= x[5];
        in_ch.pos_a_y <= y[0]; in_ch.vel_a_y <= y[1]; in_ch.acc_a_y <= y[2];
        in_ch.pos_b_y <= y[3]; in_ch.vel_b_y <= y[4]; in_ch.acc_b_y <= y[5];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // output stall: after each result a random number of cycles with ready low
    always @(negedge i_clk) begin
        if (out_wait != 0) begin
            out_ch.ready <= 1'b0;
            out_wait     <= out_wait - 1;
        end else if (out_ch.valid && out_ch.ready) begin
            // this result goes at the next edge, draw the wait for the one after
            out_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] xa[6], ya[6];
        logic [31:0] z[6];
        int guard;
        items_sent  = 0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.pos_a_x, in_ch.vel_a_x, in_ch.acc_a_x, in_ch.pos_b_x, in_ch.vel_b_x,
         in_ch.acc_b_x, in_ch.pos_a_y, in_ch.vel_a_y, in_ch.acc_a_y, in_ch.pos_b_y,
         in_ch.vel_b_y, in_ch.acc_b_y} = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: no relative motion, linear, no real root, saturation, extremes
        z = '{default: 32'h0};
        send_item(z, z);
        send_item('{32'h0, 32'h1_0000, 32'h0, 32'ha_0000, 32'h0, 32'h0},
                  '{32'h5_0000, 32'h0, 32'h0, 32'h0, 32'h2_0000, 32'h0});
        send_item('{32'h0, 32'h0, 32'h1_0000, 32'h64_0000, 32'h0, 32'h0},
                  '{32'h0, 32'h0, 32'hffff_0000, 32'h64_0000, 32'h0, 32'h0});
        send_item('{32'h8000_0000, 32'h1, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0},
                  '{32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000, 32'h1, 32'h0});
        send_item('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                  '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_item('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 32'hffff_ffff},
                  '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h8000_0000, 32'h7fff_ffff});
        send_item('{32'h0, 32'h2_0000, 32'h1_0000, 32'h0, 32'h0, 32'h0},
                  '{32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1_0000});
        in_ch.valid <= 1'b0;

        // hold off until every expected result is back
        while (pending != 0) @(negedge i_clk);

        // random part
        for (int n = 0; n < RAND_ITEMS; n++) begin
            rand_axis(xa);
            rand_axis(ya);
            send_item(xa, ya);
        end
        in_ch.valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 100 * LATENCY) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (LATENCY) @(negedge i_clk);
        $display("sent %0d items, checked %0d results", items_sent, results_seen);
        $display("covered linear, quadratic, no-motion, no-root and saturating cases");
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
